// ----- rtl/kps_pkg.sv -----
// Shared types, constants and key lookup for the matrix keypad scanner.
package kps_pkg;

   localparam int RowCount = 4;

   localparam logic [RowCount-1:0] ALL_ROWS          = 4'hF;
   localparam logic [7:0]          DEBOUNCE_RESET    = 8'd10;
   localparam logic [7:0]          COUNT_MAX         = 8'd255;
   localparam logic [7:0]          NO_CHAR           = 8'd0;

   // Scan-tick or read-and-clear, as carried by the operation field.
   typedef enum logic {
      OP_TICK = 1'b0,
      OP_READ = 1'b1
   } op_type;

   // Idle, one state per scanned row, then the release wait.
   typedef enum logic [2:0] {
      SCAN_IDLE    = 3'd0,
      SCAN_ROW0    = 3'd1,
      SCAN_ROW1    = 3'd2,
      SCAN_ROW2    = 3'd3,
      SCAN_ROW3    = 3'd4,
      SCAN_RELEASE = 3'd5
   } scan_state_type;

   typedef struct packed {
      scan_state_type        scan_state;
      logic [7:0]            release_count;
      logic [7:0]            held_char;
      logic [RowCount-1:0]   rows_driven;
   } kps_state_type;

   // ASCII of the key at a given row and column; the grid is
   // 1 2 3 / 4 5 6 / 7 8 9 / * 0 #.
   function automatic logic [7:0] key_code(input logic [1:0] row, input logic [1:0] col);
      logic [7:0] code;
      code = NO_CHAR;
      case (row)
         2'd0: code = 8'h31 + {6'd0, col};
         2'd1: code = 8'h34 + {6'd0, col};
         2'd2: code = 8'h37 + {6'd0, col};
         default: begin
            case (col)
               2'd0:    code = 8'h2A;   // '*'
               2'd1:    code = 8'h30;   // '0'
               default: code = 8'h23;   // '#'
            endcase
         end
      endcase
      return code;
   endfunction

endpackage

// ----- rtl/kps_step.sv -----
// Combinational next-state and result logic for one keypad item.
module kps_step
   import kps_pkg::*;
(
   input  kps_state_type       state_cur,
   input  logic                operation,
   input  logic [2:0]          column_levels,
   input  logic [7:0]          debounce_ticks,
   output kps_state_type       state_next,
   output logic                char_valid,
   output logic [7:0]          char_code
);

   logic       pressed;
   logic [1:0] low_col;
   logic [1:0] active_row;
   logic [7:0] count_inc;

   // Lowest-numbered low column wins.
   always_comb begin
      pressed = 1'b1;
      low_col = 2'd0;
      if (!column_levels[0]) begin
         low_col = 2'd0;
      end else if (!column_levels[1]) begin
         low_col = 2'd1;
      end else if (!column_levels[2]) begin
         low_col = 2'd2;
      end else begin
         pressed = 1'b0;
      end
   end

   assign active_row = 2'(state_cur.scan_state - SCAN_ROW0);
   assign count_inc  = (state_cur.release_count == COUNT_MAX) ?
                       COUNT_MAX : state_cur.release_count + 8'd1;

   // Next state.
   always_comb begin
      state_next = state_cur;
      if (op_type'(operation) == OP_READ) begin
         state_next.held_char = NO_CHAR;
      end else begin
         unique case (state_cur.scan_state)
            SCAN_ROW0, SCAN_ROW1, SCAN_ROW2, SCAN_ROW3: begin
               if (pressed || state_cur.scan_state == SCAN_ROW3) begin
                  if (pressed) begin
                     state_next.held_char = key_code(active_row, low_col);
                  end
                  state_next.scan_state    = SCAN_RELEASE;
                  state_next.release_count = '0;
                  state_next.rows_driven   = ALL_ROWS;
               end else begin
                  state_next.scan_state  = scan_state_type'(state_cur.scan_state + 3'd1);
                  state_next.rows_driven = state_cur.rows_driven << 1;
               end
            end
            SCAN_RELEASE: begin
               if (pressed) begin
                  state_next.release_count = '0;
               end else begin
                  state_next.release_count = count_inc;
                  if (count_inc >= debounce_ticks) begin
                     state_next.scan_state  = SCAN_IDLE;
                     state_next.rows_driven = ALL_ROWS;
                  end
               end
            end
            default: begin
               state_next.scan_state = SCAN_IDLE;
               if (pressed) begin
                  state_next.scan_state  = SCAN_ROW0;
                  state_next.rows_driven = 4'b0001;
               end
            end
         endcase
      end
   end

   // Result fields other than the row drive.
   always_comb begin
      char_valid = 1'b0;
      char_code  = NO_CHAR;
      if (op_type'(operation) == OP_READ) begin
         char_code  = state_cur.held_char;
         char_valid = (state_cur.held_char != NO_CHAR);
      end
   end

endmodule

// ----- rtl/matrix_keypad_scanner.sv -----
// Top level of the 4x3 matrix keypad scanner: state, result register and handshakes.
//
//  Channel   Ports                                   Direction  Moves
//  req       req_valid/req_stall, operation, cols    in         one tick or read item
//  rsp       rsp_valid/rsp_stall, rows, char fields  out        one result item
//  csr       csr_write_enable, csr_write_data        in         debounce tick count
//
// Every accepted item produces exactly one result item, presented in the cycle after
// acceptance; one item per cycle while req_stall is low, set by the state register update.
// The result register is one deep: while it holds an item that is stalled, req_stall is
// raised, and when the held item is taken a new item can be accepted in the same cycle.
// Synchronous active-high reset returns to idle with all rows driven, no stored character
// and a debounce count of ten; a write to the csr port changes the count at the next edge.
module matrix_keypad_scanner
   import kps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [2:0]  req_column_levels,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_row_drive,
   output logic        rsp_char_valid,
   output logic [7:0]  rsp_char_code,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   kps_state_type state_ff, state_in;
   logic [7:0]    debounce_ff;
   logic          rsp_valid_ff;
   logic [3:0]    row_drive_ff;
   logic          char_valid_ff;
   logic [7:0]    char_code_ff;
   logic          step_char_valid;
   logic [7:0]    step_char_code;
   logic          accept;

   // The input side waits only while the result register is full and its item is not taken.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   kps_step u_step (
      .state_cur      (state_ff),
      .operation      (req_operation),
      .column_levels  (req_column_levels),
      .debounce_ticks (debounce_ff),
      .state_next     (state_in),
      .char_valid     (step_char_valid),
      .char_code      (step_char_code)
   );

   // Scanner state advances once per accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.scan_state    <= SCAN_IDLE;
         state_ff.release_count <= '0;
         state_ff.held_char     <= NO_CHAR;
         state_ff.rows_driven   <= ALL_ROWS;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
      end else if (csr_write_enable) begin
         debounce_ff <= csr_write_data;
      end
   end

   // Result register: the row drive reported is the one after the step.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         row_drive_ff  <= state_in.rows_driven;
         char_valid_ff <= step_char_valid;
         char_code_ff  <= step_char_code;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_drive  = row_drive_ff;
   assign rsp_char_valid = char_valid_ff;
   assign rsp_char_code  = char_code_ff;

   // An accepted item always shows up as a result in the following cycle.
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted item produced no result");

   // Rows are either all driven or exactly one is driven during the scan.
   a_rows_shape: assert property (@(posedge clock) disable iff (reset)
      state_ff.rows_driven == ALL_ROWS || $onehot(state_ff.rows_driven))
      else $error("illegal row drive pattern");

   // Idle and release waits drive all rows.
   a_idle_all_rows: assert property (@(posedge clock) disable iff (reset)
      (state_ff.scan_state == SCAN_IDLE || state_ff.scan_state == SCAN_RELEASE)
      |-> state_ff.rows_driven == ALL_ROWS)
      else $error("rows not all driven outside the scan");

   // A result flags a character exactly when it carries a non-zero code.
   a_char_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_valid == (rsp_char_code != NO_CHAR)))
      else $error("character flag disagrees with code");

endmodule

// ----- tb/sv/kps_tb_pkg.sv -----
// Scoreboard for the keypad scanner testbench: scan prediction and result comparison.
`timescale 1ns / 100ps

package kps_tb_pkg;

   import kps_pkg::*;

   typedef struct packed {
      logic [3:0] row_drive;
      logic       char_valid;
      logic [7:0] char_code;
   } scan_result_type;

   class keypad_scoreboard;

      scan_state_type  scan;
      logic [7:0]      released_ticks;
      logic [7:0]      held_key;
      logic [3:0]      rows_low;
      logic [7:0]      debounce;
      logic [7:0]      key_ascii [0:11];
      scan_result_type awaited_scans [$];
      int unsigned     mismatches;

      function new();
         // Rows 0 to 3 of the pad: 1 2 3 / 4 5 6 / 7 8 9 / * 0 #.
         key_ascii = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
                       8'h37, 8'h38, 8'h39, 8'h2A, 8'h30, 8'h23};
         scan           = SCAN_IDLE;
         released_ticks = 8'd0;
         held_key       = NO_CHAR;
         rows_low       = ALL_ROWS;
         debounce       = DEBOUNCE_RESET;
         mismatches     = 0;
      endfunction

      function void load_debounce(logic [7:0] ticks);
         debounce = ticks;
      endfunction

      function int outstanding();
         return awaited_scans.size();
      endfunction

      // Advances the predicted scanner by one accepted item and queues its result.
      function void predict_scan(op_type op, logic [2:0] cols);
         scan_result_type predicted;
         int              col;
         int              row;
         bit              pressed;
         col = 3;
         for (int i = 2; i >= 0; i--) begin
            if (!cols[i]) begin
               col = i;
            end
         end
         pressed   = (col < 3);
         predicted = '0;
         if (op == OP_READ) begin
            predicted.char_code  = held_key;
            predicted.char_valid = (held_key != NO_CHAR);
            held_key             = NO_CHAR;
         end else begin
            case (scan)
               SCAN_ROW0, SCAN_ROW1, SCAN_ROW2, SCAN_ROW3: begin
                  row = int'(scan) - int'(SCAN_ROW0);
                  if (pressed) begin
                     held_key       = key_ascii[row * 3 + col];
                     scan           = SCAN_RELEASE;
                     released_ticks = 8'd0;
                     rows_low       = ALL_ROWS;
                  end else if (row == 3) begin
                     scan           = SCAN_RELEASE;
                     released_ticks = 8'd0;
                     rows_low       = ALL_ROWS;
                  end else begin
                     scan     = scan_state_type'(scan + 3'd1);
                     rows_low = 4'b0001 << (row + 1);
                  end
               end
               SCAN_RELEASE: begin
                  if (pressed) begin
                     released_ticks = 8'd0;
                  end else begin
                     if (released_ticks != COUNT_MAX) begin
                        released_ticks = released_ticks + 8'd1;
                     end
                     if (released_ticks >= debounce) begin
                        scan     = SCAN_IDLE;
                        rows_low = ALL_ROWS;
                     end
                  end
               end
               default: begin
                  scan = SCAN_IDLE;
                  if (pressed) begin
                     scan     = SCAN_ROW0;
                     rows_low = 4'b0001;
                  end
               end
            endcase
         end
         predicted.row_drive = rows_low;
         awaited_scans.push_back(predicted);
      endfunction

      function void compare_result(logic [3:0] row_drive, logic char_valid,
                                   logic [7:0] char_code);
         scan_result_type want;
         if (awaited_scans.size() == 0) begin
            $error("result item with no prediction waiting: row_drive %h char_code %h",
                   row_drive, char_code);
            mismatches++;
            return;
         end
         want = awaited_scans.pop_front();
         if (row_drive !== want.row_drive) begin
            $error("row_drive: expected %h, actual %h", want.row_drive, row_drive);
            mismatches++;
         end
         if (char_valid !== want.char_valid) begin
            $error("char_valid: expected %b, actual %b", want.char_valid, char_valid);
            mismatches++;
         end
         if (char_code !== want.char_code) begin
            $error("char_code: expected %h, actual %h", want.char_code, char_code);
            mismatches++;
         end
      endfunction

   endclass

endpackage

// ----- tb/sv/matrix_keypad_scanner_tb.sv -----
// Top level of the keypad scanner testbench: clock, reset, stimulus, stalls and checking.
`timescale 1ns / 100ps

module matrix_keypad_scanner_tb;

   import kps_pkg::*;
   import kps_tb_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_operation = 1'b0;
   logic [2:0] req_column_levels = 3'b111;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [3:0] rsp_row_drive;
   logic       rsp_char_valid;
   logic [7:0] rsp_char_code;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = 8'd0;

   // When set, neither side inserts idle cycles, so items flow back to back.
   bit          steady_flow = 1'b0;
   // Asks the receiver for one long hold-off, during which the block must fill up.
   bit          hold_request = 1'b0;
   int unsigned items_sent = 0;

   keypad_scoreboard sb = new();

   matrix_keypad_scanner DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_column_levels (req_column_levels),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_row_drive     (rsp_row_drive),
      .rsp_char_valid    (rsp_char_valid),
      .rsp_char_code     (rsp_char_code),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A generous ceiling: even the slowest legal run finishes far inside this.
   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Offers one item, after an optional idle gap, and returns at the edge where it is
   // taken. The caller must call again, or lower valid, without letting time pass.
   task automatic send_item(op_type op, logic [2:0] cols);
      int unsigned gap;
      gap = steady_flow ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_column_levels <= cols;
      do @(posedge clock); while (req_stall);
      sb.predict_scan(op, cols);
      items_sent++;
   endtask

   // Stops offering and waits until every predicted result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // The debounce count is only changed with nothing in flight.
   task automatic set_debounce_ticks(logic [7:0] ticks);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= ticks;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.load_debounce(ticks);
   endtask

   // A well-formed key press: a column goes low in idle, the scan walks down to the
   // chosen row (or past row 3 with nothing found), the key bounces a little, then
   // it is released for long enough and the character is usually read back.
   task automatic key_press(int unsigned debounce);
      int unsigned target_row;
      int unsigned bounces;
      int unsigned released;
      send_item(OP_TICK, 3'($urandom_range(0, 6)));
      target_row = $urandom_range(0, 4);
      for (int unsigned k = 0; k < target_row; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(OP_READ, 3'($urandom_range(0, 7)));
         end
         send_item(OP_TICK, 3'b111);
      end
      if (target_row < 4) begin
         send_item(OP_TICK, 3'($urandom_range(0, 6)));
      end
      bounces = $urandom_range(0, 3);
      repeat (bounces) send_item(OP_TICK, 3'($urandom_range(0, 7)));
      released = ((debounce == 0) ? 1 : debounce) + $urandom_range(0, 2);
      repeat (released) send_item(OP_TICK, 3'b111);
      if ($urandom_range(0, 9) < 7) begin
         send_item(OP_READ, 3'($urandom_range(0, 7)));
      end
   endtask

   // Short bursts of unstructured ticks and reads.
   task automatic noise_burst();
      int unsigned count;
      count = $urandom_range(1, 6);
      repeat (count) send_item(op_type'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
   endtask

   task automatic random_items(int unsigned debounce, int unsigned budget);
      int unsigned first;
      first = items_sent;
      while (items_sent - first < budget) begin
         if ($urandom_range(0, 99) < 85) begin
            key_press(debounce);
         end else begin
            noise_burst();
         end
      end
   endtask

   // Every accepted result item is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.compare_result(rsp_row_drive, rsp_char_valid, rsp_char_code);
      end
   end

   // The receiver draws a stall length for every item; once it honours a request
   // for a long hold-off, which it counts out itself while the sender keeps going.
   initial begin
      int unsigned pause;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            pause        = 120;
         end else begin
            pause = steady_flow ? 0 : $urandom_range(0, 14);
         end
         if (pause > 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A debounce count of zero lets a single released tick return
      // the scanner to idle, which keeps these sequences short.
      set_debounce_ticks(8'd0);
      send_item(OP_READ, 3'b000);            // nothing stored yet
      send_item(OP_TICK, 3'b111);            // idle, no key down
      send_item(OP_TICK, 3'b000);            // press starts the scan at row 0
      send_item(OP_TICK, 3'b010);            // two columns low: column 0 wins, key 1
      send_item(OP_TICK, 3'b000);            // still held: release count cleared
      send_item(OP_TICK, 3'b111);            // released, back to idle
      send_item(OP_READ, 3'b111);            // returns key 1 and clears it
      send_item(OP_READ, 3'b101);            // now empty again
      // A scan that finds nothing in any row still ends in the release wait.
      send_item(OP_TICK, 3'b011);
      send_item(OP_TICK, 3'b111);
      send_item(OP_TICK, 3'b111);
      send_item(OP_READ, 3'b000);            // a read in mid-scan leaves the scan alone
      send_item(OP_TICK, 3'b111);
      send_item(OP_TICK, 3'b111);
      send_item(OP_TICK, 3'b111);
      // Row 3, column 2 gives the hash key.
      send_item(OP_TICK, 3'b101);
      send_item(OP_TICK, 3'b111);
      send_item(OP_TICK, 3'b111);
      send_item(OP_TICK, 3'b111);
      send_item(OP_TICK, 3'b011);
      send_item(OP_TICK, 3'b111);
      // A second hit before any read replaces the stored key: row 0, column 1.
      send_item(OP_TICK, 3'b110);
      send_item(OP_TICK, 3'b101);
      send_item(OP_TICK, 3'b111);
      send_item(OP_READ, 3'b111);

      // Random part, one phase per debounce setting. The first runs back to back and
      // carries the long receiver hold-off, so the block fills and stalls its input.
      set_debounce_ticks(8'd1);
      steady_flow  = 1'b1;
      hold_request = 1'b1;
      random_items(1, 60);
      steady_flow = 1'b0;

      set_debounce_ticks(8'd10);
      random_items(10, 50);

      // The largest count needs a long run of released ticks, so one press will do.
      set_debounce_ticks(8'd255);
      key_press(255);

      set_debounce_ticks(8'd3);
      steady_flow = 1'b1;
      random_items(3, 40);
      steady_flow = 1'b0;

      begin
         int unsigned mid_ticks;
         mid_ticks = $urandom_range(2, 30);
         set_debounce_ticks(8'(mid_ticks));
         random_items(mid_ticks, 50);
      end

      set_debounce_ticks(8'd0);
      random_items(0, 40);

      drain();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
